// ----- hdl/rit_pkg.sv -----
// Ranked item table: shared widths, request codes, entry layout and
// parameter defaults. No dependencies.
`default_nettype none

package rit_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam int unsigned MAX_LEVEL_DEF = 100;
  localparam int unsigned MAX_GROUP_DEF = 100;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ID_W   = 10;
  localparam int unsigned LVL_W  = 7;
  localparam int unsigned GRP_W  = 7;

  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GROUP  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ALL    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_BOUND  = 3'd4;

  typedef struct packed {
    logic             vld;
    logic [LVL_W-1:0] level;
    logic [GRP_W-1:0] group;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/rit_req_if.sv -----
// Request channel of the ranked item table (valid/ready plus payload).
// Depends on rit_pkg.
`default_nettype none

interface rit_req_if import rit_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   item_id;
  logic [LVL_W-1:0]  item_level;
  logic [GRP_W-1:0]  item_group;
  logic              direction;

  modport source (output valid, func, item_id, item_level, item_group, direction,
                  input ready);
  modport sink   (input valid, func, item_id, item_level, item_group, direction,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/rit_rsp_if.sv -----
// Result channel of the ranked item table (valid/ready plus payload).
// Depends on rit_pkg.
`default_nettype none

interface rit_rsp_if import rit_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            found;
  logic [ID_W-1:0] result_id;

  modport source (output valid, found, result_id, input ready);
  modport sink   (input valid, found, result_id, output ready);
endinterface

`default_nettype wire

// ----- hdl/ranked_item_table_core.sv -----
// Ranked item table top level: entry memory, clear pass, query scanner.
// Depends on rit_pkg, rit_req_if, rit_rsp_if.
//
//  channel  dir  payload                                          accepted when
//  req      in   func, item_id, item_level, item_group, direction valid && ready
//  rsp      out  found, result_id                                 valid && ready
//
// Add and remove are a single write to the entry memory.
// A query scans the memory one entry a cycle; after the scan its result passes
// through ST_DRAIN and ST_FLUSH into the rsp register, req.ready low until then.
// After reset a clear pass zeroes every entry of the memory; req.ready stays low.
// A finished result waits in the rsp register; adds, removes and the next
// query's scan go on meanwhile, and a scan holds its result until rsp frees.
`default_nettype none

module ranked_item_table_core import rit_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int unsigned MAX_LEVEL = MAX_LEVEL_DEF,
  parameter int unsigned MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rit_req_if.sink   req,
  rit_rsp_if.source rsp
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned EXT_W = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ITEMS - 1);
  localparam int unsigned KEY_W = LVL_W + IDX_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    MD_ALL,
    MD_GROUP,
    MD_GE,
    MD_LT
  } mode_t;

  state_t           state;
  logic [IDX_W-1:0] scan_addr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  mode_t            mode;
  logic [LVL_W-1:0] sel;
  logic             want_max;
  logic             have;
  logic [KEY_W-1:0] best_key;
  logic             rsp_vld;
  logic             out_found;
  logic [ID_W-1:0]  out_id;

  entry_t           mem [MAX_ITEMS];

  logic [EXT_W-1:0] id_ext;
  logic             id_ok;
  logic             add_ok;
  logic             rem_ok;
  logic             is_query;
  logic             acc;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             match;
  logic [KEY_W-1:0] key;
  logic             hit;
  logic             last;
  logic             rsp_free;

  assign id_ext   = EXT_W'(req.item_id);
  assign id_ok    = id_ext < EXT_W'(MAX_ITEMS);
  assign add_ok   = (req.func == FN_ADD) && id_ok && (req.item_level != '0)
                    && ({1'b0, req.item_level} <= (LVL_W + 1)'(MAX_LEVEL))
                    && (req.item_group != '0)
                    && ({1'b0, req.item_group} <= (GRP_W + 1)'(MAX_GROUP));
  assign rem_ok   = (req.func == FN_REMOVE) && id_ok;
  assign is_query = (req.func == FN_GROUP) || (req.func == FN_ALL)
                    || (req.func == FN_BOUND);

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;
  assign last      = (scan_addr == LAST_IDX);
  assign rsp_free  = !rsp_vld || rsp.ready;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = IDX_W'(id_ext);
    wr_data = '0;
    if (state == ST_CLEAR) begin
      mem_we  = 1'b1;
      wr_addr = scan_addr;
    end else if (acc && (add_ok || rem_ok)) begin
      mem_we = 1'b1;
      if (add_ok) begin
        wr_data.vld   = 1'b1;
        wr_data.level = req.item_level;
        wr_data.group = req.item_group;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[scan_addr];
    rd_idx  <= scan_addr;
  end

  always_comb begin
    unique case (mode)
      MD_GROUP: match = (rd_data.group == sel);
      MD_GE:    match = (rd_data.level >= sel);
      MD_LT:    match = (rd_data.level < sel);
      default:  match = 1'b1;
    endcase
  end

  assign key = {rd_data.level, rd_idx};
  assign hit = rd_vld && rd_data.vld && match
               && (!have || (want_max ? (key > best_key) : (key < best_key)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      have      <= 1'b0;
      rsp_vld   <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (rsp_vld && rsp.ready && (state != ST_FLUSH)) begin
        rsp_vld <= 1'b0;
      end
      if (hit) begin
        have     <= 1'b1;
        best_key <= key;
      end
      unique case (state)
        ST_CLEAR: begin
          scan_addr <= last ? '0 : scan_addr + 1'b1;
          if (last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc && is_query) begin
            scan_addr <= '0;
            have      <= 1'b0;
            state     <= ST_SCAN;
            priority if (req.func == FN_GROUP) begin
              mode     <= MD_GROUP;
              sel      <= req.item_group;
              want_max <= req.direction;
            end else if (req.func == FN_ALL) begin
              mode     <= MD_ALL;
              sel      <= req.item_level;
              want_max <= req.direction;
            end else begin
              mode     <= req.direction ? MD_GE : MD_LT;
              sel      <= req.item_level;
              want_max <= !req.direction;
            end
          end
        end
        ST_SCAN: begin
          scan_addr <= last ? '0 : scan_addr + 1'b1;
          if (last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (rsp_free) begin
            rsp_vld   <= 1'b1;
            out_found <= have;
            out_id    <= have ? ID_W'(EXT_W'(best_key[IDX_W-1:0])) : '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid     = rsp_vld;
  assign rsp.found     = out_found;
  assign rsp.result_id = out_id;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking bench for ranked_item_table_core: directed and random adds,
// removes and queries, scored against a behavioral copy of the item table.
// Depends on rit_pkg, rit_req_if, rit_rsp_if and the core itself.
`timescale 1ns / 100ps

module tb_top import rit_pkg::*; ();

  localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;
  localparam int HOLD_CYCLES = 4000;
  localparam int RANDOM_ITEMS = 560;
  localparam int SEGMENT = 40;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } answer_t;

  typedef enum {SCAN_ALL, SCAN_GROUP, SCAN_AT_OR_ABOVE, SCAN_BELOW} scan_t;

  class rank_table_scoreboard;
    bit              used   [MAX_ITEMS_DEF];
    logic [LVL_W-1:0] lvl_of [MAX_ITEMS_DEF];
    logic [GRP_W-1:0] grp_of [MAX_ITEMS_DEF];
    answer_t         answers_due[$];
    int              errors;

    function answer_t best_item(scan_t mode, logic [LVL_W-1:0] sel, bit want_max);
      answer_t ans;
      bit have;
      bit hit;
      logic [LVL_W+ID_W-1:0] key;
      logic [LVL_W+ID_W-1:0] best;
      have = 0;
      best = '0;
      for (int i = 0; i < MAX_ITEMS_DEF; i++) begin
        if (used[i]) begin
          case (mode)
            SCAN_GROUP:       hit = (grp_of[i] == sel);
            SCAN_AT_OR_ABOVE: hit = (lvl_of[i] >= sel);
            SCAN_BELOW:       hit = (lvl_of[i] < sel);
            default:          hit = 1;
          endcase
          key = {lvl_of[i], i[ID_W-1:0]};
          if (hit && (!have || (want_max ? key > best : key < best))) begin
            best = key;
            have = 1;
          end
        end
      end
      ans.found = have;
      ans.id = have ? best[ID_W-1:0] : '0;
      return ans;
    endfunction

    function void note_request(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                               logic [LVL_W-1:0] lvl, logic [GRP_W-1:0] grp,
                               logic dir);
      case (fn)
        FN_ADD: begin
          if (lvl >= 1 && lvl <= MAX_LEVEL_DEF && grp >= 1 && grp <= MAX_GROUP_DEF) begin
            used[id] = 1;
            lvl_of[id] = lvl;
            grp_of[id] = grp;
          end
        end
        FN_REMOVE: used[id] = 0;
        FN_GROUP:  answers_due.push_back(best_item(SCAN_GROUP, grp, dir));
        FN_ALL:    answers_due.push_back(best_item(SCAN_ALL, '0, dir));
        FN_BOUND: begin
          if (dir) answers_due.push_back(best_item(SCAN_AT_OR_ABOVE, lvl, 1'b0));
          else     answers_due.push_back(best_item(SCAN_BELOW, lvl, 1'b1));
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic found, logic [ID_W-1:0] id);
      answer_t want;
      if (answers_due.size() == 0) begin
        $error("unexpected result: found %0d result_id %0d", found, id);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (id !== want.id) begin
          $error("result_id: expected %0d, got %0d", want.id, id);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 0;
  int   results_seen = 0;
  bit   held = 0;

  rit_req_if req_ch ();
  rit_rsp_if rsp_ch ();

  rank_table_scoreboard sb = new();

  ranked_item_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #25_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_req(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                          logic [LVL_W-1:0] lvl, logic [GRP_W-1:0] grp, logic dir);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= fn;
    req_ch.item_id    <= id;
    req_ch.item_level <= lvl;
    req_ch.item_group <= grp;
    req_ch.direction  <= dir;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(fn, id, lvl, grp, dir);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 1023))
                                       : ID_W'($urandom_range(0, 47));
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 7'd0;
    if (r < 8) return LVL_W'($urandom_range(101, 127));
    if (r < 12) return 7'd1;
    if (r < 16) return 7'd100;
    if (r < 55) return LVL_W'($urandom_range(40, 44));
    return LVL_W'($urandom_range(1, 100));
  endfunction

  function automatic logic [GRP_W-1:0] pick_group();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 7'd0;
    if (r < 6) return GRP_W'($urandom_range(101, 127));
    if (r < 14) return GRP_W'($urandom_range(1, 100));
    return GRP_W'($urandom_range(1, 6));
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      send_req(FN_ADD, pick_id(), pick_level(), pick_group(), 1'($urandom_range(0, 1)));
    else if (r < 55)
      send_req(FN_REMOVE, pick_id(), LVL_W'($urandom_range(0, 127)),
               GRP_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    else if (r < 67)
      send_req(FN_GROUP, ID_W'($urandom_range(0, 1023)), LVL_W'($urandom_range(0, 127)),
               pick_group(), 1'($urandom_range(0, 1)));
    else if (r < 77)
      send_req(FN_ALL, ID_W'($urandom_range(0, 1023)), LVL_W'($urandom_range(0, 127)),
               GRP_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    else if (r < 96)
      send_req(FN_BOUND, ID_W'($urandom_range(0, 1023)),
               LVL_W'(($urandom_range(0, 1) == 1) ? $urandom_range(35, 50)
                                                  : $urandom_range(0, 127)),
               GRP_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    else
      send_req(FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)), pick_id(), pick_level(),
               pick_group(), 1'($urandom_range(0, 1)));
  endtask

  // result side: random stall per result, one long hold-off early in the random part
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait();
      @(negedge clk);
      if (results_seen == 20 && !held) begin
        held = 1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_result(rsp_ch.found, rsp_ch.result_id);
      results_seen++;
    end
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.func       = FN_ADD;
    req_ch.item_id    = '0;
    req_ch.item_level = '0;
    req_ch.item_group = '0;
    req_ch.direction  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty table
    send_req(FN_ALL,    10'd0,    7'd0,   7'd0,   1'b1);
    send_req(FN_GROUP,  10'd0,    7'd0,   7'd1,   1'b0);
    send_req(FN_BOUND,  10'd0,    7'd0,   7'd0,   1'b1);
    // extremes, overwrite, rejected adds, removes, spare func codes and queries
    send_req(FN_ADD,    10'd0,    7'd1,   7'd1,   1'b0);
    send_req(FN_ADD,    10'd1023, 7'd100, 7'd100, 1'b1);
    send_req(FN_ADD,    10'd512,  7'd50,  7'd1,   1'b0);
    send_req(FN_ADD,    10'd512,  7'd100, 7'd1,   1'b0);
    send_req(FN_ADD,    10'd300,  7'd0,   7'd5,   1'b0);
    send_req(FN_ADD,    10'd301,  7'd127, 7'd5,   1'b0);
    send_req(FN_ADD,    10'd302,  7'd20,  7'd0,   1'b0);
    send_req(FN_ADD,    10'd303,  7'd20,  7'd127, 1'b0);
    send_req(FN_REMOVE, 10'd777,  7'd0,   7'd0,   1'b0);
    send_req(FN_SPARE_LO, 10'd5,  7'd5,   7'd5,   1'b1);
    send_req(FN_SPARE_MID, 10'd6, 7'd6,   7'd6,   1'b0);
    send_req(FN_SPARE_HI, 10'd7,  7'd7,   7'd7,   1'b1);
    send_req(FN_GROUP,  10'd0,    7'd0,   7'd5,   1'b1);
    send_req(FN_GROUP,  10'd0,    7'd0,   7'd1,   1'b1);
    send_req(FN_ALL,    10'd0,    7'd0,   7'd0,   1'b0);
    send_req(FN_BOUND,  10'd0,    7'd127, 7'd0,   1'b0);
    send_req(FN_BOUND,  10'd0,    7'd101, 7'd0,   1'b1);
    send_req(FN_BOUND,  10'd0,    7'd100, 7'd0,   1'b1);
    send_req(FN_BOUND,  10'd0,    7'd50,  7'd0,   1'b0);
    send_req(FN_REMOVE, 10'd1023, 7'd0,   7'd0,   1'b0);
    send_req(FN_ALL,    10'd0,    7'd0,   7'd0,   1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / SEGMENT) % 4) == 3;
      send_random();
    end
    steady = 0;

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
    repeat (MAX_ITEMS_DEF + 16) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rit_pkg.sv
hdl/rit_req_if.sv
hdl/rit_rsp_if.sv
hdl/ranked_item_table_core.sv
dv/tb_top.sv
